// ----- src/gdfs_pkg.sv -----
`default_nettype none
package gdfs_pkg;
   localparam int MaxVertices = 64;
   localparam int VertexWidth = 7;
   localparam int IndexWidth  = $clog2(MaxVertices);

   typedef enum logic [1:0] {
      ACT_ARC    = 2'd0,
      ACT_EDGE   = 2'd1,
      ACT_START  = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   localparam logic [VertexWidth-1:0] CsrVertexCount  = 7'd0;
   localparam logic [VertexWidth-1:0] CsrUseTranspose = 7'd1;

   typedef struct packed {
      action_type             action;
      logic [VertexWidth-1:0] vertex_u;
      logic [VertexWidth-1:0] vertex_v;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [VertexWidth-1:0] vertex;
      logic [VertexWidth-1:0] parent;
      logic [7:0]             discover_time;
      logic [7:0]             finish_time;
      logic [12:0]            edge_count;
      logic                   last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE,
      ST_INIT,
      ST_ROOT,
      ST_TOP,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic do_clear;
      logic do_edge;
      logic do_init;
      logic do_root;
      logic do_top;
      logic do_scan;
      logic do_emit_rd;
      logic do_emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic init_done;
      logic roots_done;
      logic root_ok;
      logic stack_empty;
      logic scan_done;
      logic emit_done;
      logic none_finished;
   } status_type;
endpackage
`default_nettype wire

// ----- src/gdfs_control.sv -----
`default_nettype none
module gdfs_control import gdfs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       search_go,
   input  wire logic       clear_go,
   input  wire logic       edge_go,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (clear_go)       state_in = ST_CLEAR;
            else if (search_go) state_in = ST_INIT;
            else if (edge_go)   state_in = ST_EDGE;
         end
         ST_CLEAR: begin
            cmd.do_clear = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_EDGE: begin
            cmd.do_edge = 1'b1;
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            cmd.do_init = 1'b1;
            if (status.init_done) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.do_root = 1'b1;
            if (status.roots_done)
               state_in = status.none_finished ? ST_IDLE : ST_EMIT_RD;
            else if (status.root_ok) state_in = ST_TOP;
         end
         ST_TOP: begin
            cmd.do_top = 1'b1;
            state_in = status.stack_empty ? ST_ROOT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.do_scan = 1'b1;
            if (status.scan_done) state_in = ST_TOP;
         end
         ST_EMIT_RD: begin
            cmd.do_emit_rd = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.do_emit = 1'b1;
            state_in = status.emit_done ? ST_IDLE : ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_clear_only_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && clear_go) |=> state_ff == ST_CLEAR)
      else $error("clear not started");
   a_one_cmd: assert property (@(posedge clock) $onehot0(cmd))
      else $error("more than one command");
   a_emit_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.do_emit |-> $past(cmd.do_emit_rd))
      else $error("emit without read");
endmodule
`default_nettype wire

// ----- src/gdfs_datapath.sv -----
`default_nettype none
module gdfs_datapath import gdfs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_take,
   input  wire req_type           req_item,
   input  wire logic [VertexWidth-1:0] vertex_count,
   input  wire logic              use_transpose,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item
);
   localparam int CountWidth = IndexWidth + 1;
   typedef logic [MaxVertices-1:0] row_type;

   // adjacency matrices, each row read at one signal address per cycle
   row_type rows_mem [MaxVertices];
   row_type cols_mem [MaxVertices];
   logic [VertexWidth-1:0] parent_mem [MaxVertices];
   logic [7:0] disc_mem [MaxVertices];
   logic [7:0] fin_mem [MaxVertices];
   logic [VertexWidth-1:0] stack_vert_mem [MaxVertices];
   logic [VertexWidth:0]   stack_next_mem [MaxVertices];
   logic [VertexWidth-1:0] start_mem [MaxVertices];
   logic [VertexWidth-1:0] seq_mem [MaxVertices];
   row_type white_ff;

   logic [CountWidth-1:0] start_count_ff, root_idx_ff, depth_ff, fin_count_ff, emit_k_ff;
   logic [CountWidth-1:0] sweep_ff;
   logic [7:0]  time_ff;
   logic [12:0] edges_ff;
   logic [VertexWidth-1:0] top_vert_ff;
   logic [VertexWidth:0]   top_next_ff;
   row_type top_row_ff;
   logic [VertexWidth-1:0] emit_v_ff;
   logic                   emit_last_ff;
   logic [VertexWidth-1:0] root_v_ff;

   logic [VertexWidth-1:0] n_active;
   assign n_active = (vertex_count > VertexWidth'(MaxVertices)) ?
                     VertexWidth'(MaxVertices) : vertex_count;

   // edge insert: both rows are read at the accepting edge, updated next cycle
   logic u_ok, v_ok, edge_ok;
   logic [IndexWidth-1:0] ui, vi;
   assign u_ok = req_item.vertex_u != '0 && req_item.vertex_u <= n_active;
   assign v_ok = req_item.vertex_v != '0 && req_item.vertex_v <= n_active;
   assign ui = IndexWidth'(req_item.vertex_u - 1'b1);
   assign vi = IndexWidth'(req_item.vertex_v - 1'b1);
   assign edge_ok = req_take && (req_item.action == ACT_ARC || req_item.action == ACT_EDGE)
                    && u_ok && v_ok;
   logic edge_ok_ff, edge_both_ff;
   logic [IndexWidth-1:0] eu_ff, ev_ff;
   row_type row_u_ff, row_v_ff;
   logic fresh;
   assign fresh = !row_u_ff[ev_ff] || (edge_both_ff && !row_v_ff[eu_ff]);

   // neighbor candidates of the top vertex, next index onward, white only
   row_type cand;
   logic found;
   logic [IndexWidth-1:0] found_idx;
   always_comb begin
      cand = top_row_ff & white_ff;
      for (int i = 0; i < MaxVertices; i++)
         if (VertexWidth'(i) >= n_active || (VertexWidth+1)'(i + 1) < top_next_ff)
            cand[i] = 1'b0;
   end
   always_comb begin
      found = 1'b0;
      found_idx = '0;
      for (int i = MaxVertices - 1; i >= 0; i--)
         if (cand[i]) begin
            found = 1'b1;
            found_idx = IndexWidth'(i);
         end
   end
   logic push;
   assign push = found && depth_ff < CountWidth'(MaxVertices);

   // queued start is fetched one step ahead of its use
   logic [VertexWidth-1:0] root_v;
   logic root_valid;
   assign root_v = root_v_ff;
   assign root_valid = root_v != '0 && root_v <= n_active &&
                       white_ff[IndexWidth'(root_v - 1'b1)];

   assign status.clear_done    = sweep_ff == CountWidth'(MaxVertices - 1);
   assign status.init_done     = 1'b1;
   assign status.roots_done    = root_idx_ff >= start_count_ff;
   assign status.root_ok       = root_valid;
   assign status.stack_empty   = depth_ff == '0;
   assign status.scan_done     = 1'b1;
   assign status.emit_done     = emit_last_ff;
   assign status.none_finished = fin_count_ff == '0;

   logic [7:0] time_inc;
   assign time_inc = time_ff + 8'd1;
   logic [IndexWidth-1:0] top_i;
   assign top_i = IndexWidth'(top_vert_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.do_clear) begin
         rows_mem[sweep_ff[IndexWidth-1:0]]   <= '0;
         cols_mem[sweep_ff[IndexWidth-1:0]]   <= '0;
         parent_mem[sweep_ff[IndexWidth-1:0]] <= '0;
         disc_mem[sweep_ff[IndexWidth-1:0]]   <= '0;
         fin_mem[sweep_ff[IndexWidth-1:0]]    <= '0;
      end else if (cmd.do_edge && edge_ok_ff) begin
         rows_mem[eu_ff][ev_ff] <= 1'b1;
         cols_mem[ev_ff][eu_ff] <= 1'b1;
         if (edge_both_ff) begin
            rows_mem[ev_ff][eu_ff] <= 1'b1;
            cols_mem[eu_ff][ev_ff] <= 1'b1;
         end
      end
      if (req_take && req_item.action == ACT_START && req_item.vertex_u != '0 &&
          req_item.vertex_u <= VertexWidth'(MaxVertices) &&
          start_count_ff < CountWidth'(MaxVertices))
         start_mem[start_count_ff[IndexWidth-1:0]] <= req_item.vertex_u;
      if (cmd.do_root && !status.roots_done && root_valid) begin
         disc_mem[IndexWidth'(root_v - 1'b1)] <= time_inc;
         parent_mem[IndexWidth'(root_v - 1'b1)] <= '0;
         stack_vert_mem[0] <= root_v;
         stack_next_mem[0] <= (VertexWidth+1)'(1);
      end
      if (cmd.do_scan) begin
         if (found && depth_ff < CountWidth'(MaxVertices)) begin
            stack_next_mem[IndexWidth'(depth_ff - 1'b1)] <= (VertexWidth+1)'(found_idx) + 2'd2;
            stack_vert_mem[depth_ff[IndexWidth-1:0]] <= VertexWidth'(found_idx) + 1'b1;
            stack_next_mem[depth_ff[IndexWidth-1:0]] <= (VertexWidth+1)'(1);
            parent_mem[found_idx] <= top_vert_ff;
            disc_mem[found_idx]   <= time_inc;
         end else begin
            fin_mem[top_i] <= time_inc;
            seq_mem[fin_count_ff[IndexWidth-1:0]] <= top_vert_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         edge_ok_ff   <= edge_ok;
         edge_both_ff <= req_item.action == ACT_EDGE;
         eu_ff        <= ui;
         ev_ff        <= vi;
         row_u_ff     <= rows_mem[ui];
         row_v_ff     <= rows_mem[vi];
      end
      if (cmd.do_init) root_v_ff <= start_mem[0];
      else if (cmd.do_root && !status.roots_done)
         root_v_ff <= start_mem[IndexWidth'(root_idx_ff + 1'b1)];
      // top of stack kept in registers; a pop fetches the entry below
      if (cmd.do_root && !status.roots_done && root_valid) begin
         top_vert_ff <= root_v;
         top_next_ff <= (VertexWidth+1)'(1);
      end
      if (cmd.do_scan) begin
         if (push) begin
            top_vert_ff <= VertexWidth'(found_idx) + 1'b1;
            top_next_ff <= (VertexWidth+1)'(1);
         end else begin
            top_vert_ff <= stack_vert_mem[IndexWidth'(depth_ff - 2'd2)];
            top_next_ff <= stack_next_mem[IndexWidth'(depth_ff - 2'd2)];
         end
      end
      if (cmd.do_top)
         top_row_ff <= use_transpose ? cols_mem[top_i] : rows_mem[top_i];
      if (cmd.do_emit_rd) begin
         emit_v_ff    <= seq_mem[IndexWidth'(fin_count_ff - emit_k_ff - 1'b1)];
         emit_last_ff <= emit_k_ff + 1'b1 == fin_count_ff;
      end
      rsp_item.vertex        <= emit_v_ff;
      rsp_item.parent        <= parent_mem[IndexWidth'(emit_v_ff - 1'b1)];
      rsp_item.discover_time <= disc_mem[IndexWidth'(emit_v_ff - 1'b1)];
      rsp_item.finish_time   <= fin_mem[IndexWidth'(emit_v_ff - 1'b1)];
      rsp_item.edge_count    <= edges_ff;
      rsp_item.last_result   <= emit_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0; start_count_ff <= '0; time_ff <= '0; edges_ff <= '0;
         white_ff <= '1; depth_ff <= '0; root_idx_ff <= '0; fin_count_ff <= '0;
         emit_k_ff <= '0; rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.do_emit;
         if (cmd.do_clear) begin
            sweep_ff <= status.clear_done ? '0 : sweep_ff + 1'b1;
            start_count_ff <= '0; time_ff <= '0; edges_ff <= '0; white_ff <= '1;
         end
         if (cmd.do_edge && edge_ok_ff && fresh && edges_ff != 13'h1FFF)
            edges_ff <= edges_ff + 1'b1;
         if (req_take && req_item.action == ACT_CLEAR) sweep_ff <= '0;
         if (req_take && req_item.action == ACT_START && req_item.vertex_u != '0 &&
             req_item.vertex_u <= VertexWidth'(MaxVertices) &&
             start_count_ff < CountWidth'(MaxVertices))
            start_count_ff <= start_count_ff + 1'b1;
         if (cmd.do_init) begin
            white_ff <= '1; time_ff <= '0; depth_ff <= '0; root_idx_ff <= '0;
            fin_count_ff <= '0; emit_k_ff <= '0;
         end
         if (cmd.do_root) begin
            if (status.roots_done) start_count_ff <= '0;
            else begin
               root_idx_ff <= root_idx_ff + 1'b1;
               if (root_valid) begin
                  time_ff <= time_inc;
                  white_ff[IndexWidth'(root_v - 1'b1)] <= 1'b0;
                  depth_ff <= CountWidth'(1);
               end
            end
         end
         if (cmd.do_scan) begin
            time_ff <= time_inc;
            if (found && depth_ff < CountWidth'(MaxVertices)) begin
               white_ff[found_idx] <= 1'b0;
               depth_ff <= depth_ff + 1'b1;
            end else begin
               depth_ff <= depth_ff - 1'b1;
               fin_count_ff <= fin_count_ff + 1'b1;
            end
         end
         if (cmd.do_emit) emit_k_ff <= emit_k_ff + 1'b1;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CountWidth'(MaxVertices)) else $error("stack overflow");
   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.do_emit)) else $error("stray strobe");
   a_fin_bound: assert property (@(posedge clock) disable iff (reset)
      fin_count_ff <= CountWidth'(MaxVertices)) else $error("finish overflow");
endmodule
`default_nettype wire

// ----- src/graph_depth_first_search_unit.sv -----
`default_nettype none
// Depth-first search unit over an adjacency bit matrix.
// Request channel: an item is taken when start is high and busy is low.
//   Queued start items stream at one per cycle.
//   Arc and edge items: the rows are read at the accepting edge and updated
//   in the next cycle with busy high, so no item is taken during the update.
// Clear item: busy while the matrix rows and the per-vertex stores are
//   swept to zero, one row per cycle.
// Search item (start with last set): busy while the walk runs. Each stack
//   step is a row read of the top vertex, then a neighbor scan through a
//   priority encoder over that row. Busy stays high while results stream out.
// Results: rsp_strobe marks each result for one cycle, in decreasing finish
//   order, last_result set on the final one. The receiver cannot stall.
// Reset: synchronous; after reset the unit runs the same sweep as a clear
//   (busy high) before it takes items. csr writes are taken at any time;
//   vertex_count resets to 64, use_transpose to 0.
module graph_depth_first_search_unit import gdfs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_item,
   output logic            rsp_strobe,
   output rsp_type         rsp_item,
   input  wire logic       csr_write,
   input  wire logic [VertexWidth-1:0] csr_index,
   input  wire logic [VertexWidth-1:0] csr_data
);
   logic [VertexWidth-1:0] vertex_count_ff;
   logic                   use_transpose_ff;
   cmd_type    cmd;
   status_type status;
   logic       req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff  <= VertexWidth'(64);
         use_transpose_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == CsrVertexCount)       vertex_count_ff  <= csr_data;
         else if (csr_index == CsrUseTranspose) use_transpose_ff <= csr_data[0];
      end
   end

   assign req_take = start && !busy;

   gdfs_control u_control (
      .clock(clock), .reset(reset),
      .search_go(req_take && req_item.action == ACT_START && req_item.last),
      .clear_go(req_take && req_item.action == ACT_CLEAR),
      .edge_go(req_take && (req_item.action == ACT_ARC || req_item.action == ACT_EDGE)),
      .status(status), .cmd(cmd), .busy(busy)
   );

   gdfs_datapath u_datapath (
      .clock(clock), .reset(reset), .req_take(req_take), .req_item(req_item),
      .vertex_count(vertex_count_ff), .use_transpose(use_transpose_ff),
      .cmd(cmd), .status(status), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import gdfs_pkg::*;

   // dut ports
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_write;
   logic [VertexWidth-1:0] csr_index;
   logic [VertexWidth-1:0] csr_data;

   int error_count = 0;
   int idle_cycles = 0;
   int item_total  = 0;
   bit no_gap_run  = 0;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 200;

   // one line per mismatch, counted for the final verdict
   task automatic report(input string what);
      error_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // Scoreboard: mirrors the graph and the search, keeps the walk output
   // it expects in finish order, newest finish first.
   class dfs_scoreboard;
      bit [63:0] out_rows [64];
      bit [63:0] in_cols  [64];
      bit [1:0]  color [64];
      bit [6:0]  tree_parent [64];
      bit [7:0]  found_at [64];
      bit [7:0]  done_at  [64];
      bit [6:0]  root_list [$];
      bit [12:0] edges;
      bit [6:0]  vcount;
      bit        reversed;
      rsp_type   walk_output [$];

      function new();
         vcount   = 7'd64;
         reversed = 1'b0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < 64; i++) begin
            out_rows[i] = '0;
            in_cols[i] = '0;
            color[i] = 2'd0;
            tree_parent[i] = '0;
            found_at[i] = '0;
            done_at[i] = '0;
         end
         root_list.delete();
         edges = '0;
      endfunction

      function void set_reg(input bit [6:0] index, input bit [6:0] data);
         if (index == CsrVertexCount) vcount = data;
         else if (index == CsrUseTranspose) reversed = data[0];
      endfunction

      function int active();
         return (vcount > 64) ? 64 : vcount;
      endfunction

      // returns 1 when the arc was not there yet
      function bit put_arc(input int u, input int v);
         if (out_rows[u-1][v-1]) return 0;
         out_rows[u-1][v-1] = 1'b1;
         in_cols[v-1][u-1] = 1'b1;
         return 1;
      endfunction

      function bit linked(input int x, input int y);
         return reversed ? in_cols[x-1][y-1] : out_rows[x-1][y-1];
      endfunction

      function void walk_graph();
         int n;
         int depth;
         int clock_stamp;
         int stack_vert [64];
         int stack_next [64];
         int finish_list [$];
         int x;
         int y;
         rsp_type r;
         n = active();
         clock_stamp = 0;
         for (int i = 0; i < 64; i++) begin
            color[i] = 2'd0;
            tree_parent[i] = '0;
         end
         foreach (root_list[s]) begin
            int root;
            root = root_list[s];
            if (root < 1 || root > n || color[root-1] != 2'd0) continue;
            clock_stamp = (clock_stamp + 1) & 8'hFF;
            found_at[root-1] = clock_stamp;
            color[root-1] = 2'd1;
            stack_vert[0] = root;
            stack_next[0] = 1;
            depth = 1;
            while (depth > 0) begin
               x = stack_vert[depth-1];
               y = stack_next[depth-1];
               while (y <= n && !(linked(x, y) && color[y-1] == 2'd0)) y++;
               if (y <= n && depth < 64) begin
                  stack_next[depth-1] = y + 1;
                  tree_parent[y-1] = x;
                  clock_stamp = (clock_stamp + 1) & 8'hFF;
                  found_at[y-1] = clock_stamp;
                  color[y-1] = 2'd1;
                  stack_vert[depth] = y;
                  stack_next[depth] = 1;
                  depth++;
               end else begin
                  color[x-1] = 2'd2;
                  clock_stamp = (clock_stamp + 1) & 8'hFF;
                  done_at[x-1] = clock_stamp;
                  if (finish_list.size() < 64) finish_list.push_back(x);
                  depth--;
               end
            end
         end
         root_list.delete();
         for (int k = finish_list.size() - 1; k >= 0; k--) begin
            x = finish_list[k];
            r.vertex = x;
            r.parent = tree_parent[x-1];
            r.discover_time = found_at[x-1];
            r.finish_time = done_at[x-1];
            r.edge_count = edges;
            r.last_result = (k == 0);
            walk_output.push_back(r);
         end
      endfunction

      // accepted request: update the mirror, queue any walk output
      function void note_item(input req_type it);
         int n;
         bit fresh;
         n = active();
         case (it.action)
            ACT_ARC, ACT_EDGE: begin
               if (it.vertex_u >= 1 && it.vertex_u <= n &&
                   it.vertex_v >= 1 && it.vertex_v <= n) begin
                  fresh = put_arc(it.vertex_u, it.vertex_v);
                  if (it.action == ACT_EDGE)
                     fresh = put_arc(it.vertex_v, it.vertex_u) | fresh;
                  if (fresh && edges != 13'h1FFF) edges++;
               end
            end
            ACT_CLEAR: wipe();
            ACT_START: begin
               if (it.vertex_u >= 1 && it.vertex_u <= 64 && root_list.size() < 64)
                  root_list.push_back(it.vertex_u);
               if (it.last) walk_graph();
            end
         endcase
      endfunction

      task check_result(input rsp_type got);
         rsp_type want;
         if (walk_output.size() == 0) begin
            report($sformatf("unexpected result vertex %0d", got.vertex));
            return;
         end
         want = walk_output.pop_front();
         if (got.vertex !== want.vertex)
            report($sformatf("vertex %0d, want %0d", got.vertex, want.vertex));
         if (got.parent !== want.parent)
            report($sformatf("parent %0d, want %0d (v%0d)", got.parent, want.parent,
                             want.vertex));
         if (got.discover_time !== want.discover_time)
            report($sformatf("discover %0d, want %0d (v%0d)", got.discover_time,
                             want.discover_time, want.vertex));
         if (got.finish_time !== want.finish_time)
            report($sformatf("finish %0d, want %0d (v%0d)", got.finish_time,
                             want.finish_time, want.vertex));
         if (got.edge_count !== want.edge_count)
            report($sformatf("edge count %0d, want %0d", got.edge_count,
                             want.edge_count));
         if (got.last_result !== want.last_result)
            report($sformatf("last flag %0b, want %0b (v%0d)", got.last_result,
                             want.last_result, want.vertex));
      endtask

      function int pending();
         return walk_output.size();
      endfunction
   endclass

   dfs_scoreboard search_board = new();

   graph_depth_first_search_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // results can't be held off: take every strobed item at the edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) search_board.check_result(rsp_item);
   end

   // watchdog: cycles with neither an accepted item nor a result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   // mostly short gaps, a few long ones; some stretches back to back
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_gap_run || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive one item and hold it until the unit takes it
   task automatic send(input action_type act, input bit [6:0] u, input bit [6:0] v,
                       input bit fin);
      int gap;
      start <= 1'b1;
      req_item <= '{action: act, vertex_u: u, vertex_v: v, last: fin};
      @(posedge clock);
      while (busy) @(posedge clock);
      search_board.note_item('{action: act, vertex_u: u, vertex_v: v, last: fin});
      item_total++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         req_item <= '{action: action_type'($urandom_range(3)),
                       vertex_u: 7'($urandom), vertex_v: 7'($urandom), last: 1'($urandom)};
         repeat (gap) @(posedge clock);
      end
   endtask

   // unit idle: nothing outstanding, not busy, then a short settle
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (search_board.pending() > 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input bit [6:0] index, input bit [6:0] data);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      search_board.set_reg(index, data);
      csr_write <= 1'b0;
   endtask

   // vertex in range most of the time, any 7-bit code otherwise
   function automatic bit [6:0] pick_vertex(input int n);
      if (n < 1 || $urandom_range(9) == 0) return 7'($urandom);
      return 7'($urandom_range(1, n));
   endfunction

   initial begin
      int n;
      int roots;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: ends of the vertex range, self loop, duplicates,
      // out-of-range ends and starts, transpose, empty search
      write_reg(CsrVertexCount, 7'd64);
      send(ACT_ARC, 7'd1, 7'd64, 1'b0);
      send(ACT_ARC, 7'd64, 7'd1, 1'b0);
      send(ACT_ARC, 7'd1, 7'd64, 1'b0);          // duplicate arc
      send(ACT_EDGE, 7'd2, 7'd1, 1'b0);
      send(ACT_EDGE, 7'd1, 7'd2, 1'b0);          // duplicate edge
      send(ACT_ARC, 7'd5, 7'd5, 1'b0);           // self loop
      send(ACT_ARC, 7'd0, 7'd3, 1'b0);           // zero end
      send(ACT_EDGE, 7'd3, 7'd65, 1'b0);         // end above range
      send(ACT_EDGE, 7'd127, 7'd127, 1'b0);
      send(ACT_START, 7'd0, 7'd0, 1'b0);         // not queued
      send(ACT_START, 7'd127, 7'd127, 1'b0);     // not queued
      send(ACT_START, 7'd64, 7'd0, 1'b0);
      send(ACT_START, 7'd5, 7'd127, 1'b1);
      write_reg(CsrUseTranspose, 7'd1);
      send(ACT_START, 7'd1, 7'd0, 1'b1);
      write_reg(CsrUseTranspose, 7'd0);
      write_reg(CsrVertexCount, 7'd3);           // queued 64 now skipped
      send(ACT_START, 7'd64, 7'd0, 1'b0);
      send(ACT_START, 7'd1, 7'd0, 1'b1);
      write_reg(CsrVertexCount, 7'd0);           // no vertex in use
      send(ACT_ARC, 7'd1, 7'd1, 1'b0);
      send(ACT_START, 7'd1, 7'd0, 1'b1);         // empty search
      write_reg(CsrVertexCount, 7'd100);         // acts as 64
      send(ACT_START, 7'd2, 7'd0, 1'b1);
      send(ACT_CLEAR, 7'd0, 7'd0, 1'b0);
      send(ACT_START, 7'd1, 7'd0, 1'b1);

      // random: build a graph, queue some roots, search; some noise
      while (item_total < 350) begin
         no_gap_run = ($urandom_range(4) == 0);
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(9))
               0: write_reg(CsrVertexCount, 7'd1);
               1: write_reg(CsrVertexCount, 7'd64);
               2: write_reg(CsrVertexCount, 7'd2);
               default: write_reg(CsrVertexCount, 7'($urandom_range(3, 12)));
            endcase
            write_reg(CsrUseTranspose, 7'($urandom_range(1)));
         end
         n = search_board.active();
         if ($urandom_range(4) == 0) send(ACT_CLEAR, 7'($urandom), 7'($urandom), 1'($urandom));
         repeat ($urandom_range(0, (n > 16) ? 30 : 2 * n))
            send($urandom_range(1) ? ACT_EDGE : ACT_ARC, pick_vertex(n), pick_vertex(n),
                 1'($urandom));
         if ($urandom_range(7) == 0)
            send(action_type'($urandom_range(3)), 7'($urandom), 7'($urandom), 1'b0);
         // now and then overflow the root queue
         roots = ($urandom_range(19) == 0) ? 68 : $urandom_range(1, 4);
         for (int r = 1; r < roots; r++) send(ACT_START, pick_vertex(n), 7'($urandom), 1'b0);
         send(ACT_START, pick_vertex(n), 7'($urandom), 1'b1);
      end

      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && search_board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         if (search_board.pending() > 0)
            report($sformatf("%0d results never arrived", search_board.pending()));
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
src/gdfs_pkg.sv
src/gdfs_control.sv
src/gdfs_datapath.sv
src/graph_depth_first_search_unit.sv
sim/tb.sv
